[hdl/dacc_pkg.sv]
// ----------------------------------------------------------------------------
// dacc_pkg
// Shared widths, configuration register indexes and limits of the door
// auto-close controller.
// ----------------------------------------------------------------------------
package dacc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 4;
  localparam int unsigned PressW    = 16;
  localparam int unsigned StateW    = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 48;

  localparam logic [TimeW-1:0]  AutoCloseMin   = 32'd60000;
  localparam logic [TimeW-1:0]  TravelMin      = 32'd1000;
  localparam logic [CountW-1:0] AttemptMax     = 4'd10;
  localparam logic [CountW-1:0] AttemptMin     = 4'd1;

  localparam logic [TimeW-1:0]  AutoCloseReset = 32'd300000;
  localparam logic [TimeW-1:0]  TravelReset    = 32'd30000;
  localparam logic [CountW-1:0] AttemptsReset  = 4'd3;
  localparam logic [PressW-1:0] PressReset     = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_CLOSE   = 3'd0,
    CFG_TRAVEL       = 3'd1,
    CFG_MAX_ATTEMPTS = 3'd2,
    CFG_PRESS        = 3'd3,
    CFG_BUTTON_LEVEL = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    REQ_POLL   = 1'b0,
    REQ_MANUAL = 1'b1
  } req_e;

endpackage

[hdl/door_auto_close_controller.sv]
// ----------------------------------------------------------------------------
// door_auto_close_controller
// Classifies a door from its limit sensors, runs the auto-close timer and
// drives the opener button pulse, one result per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Contents
//  s_axis    in         s_axis_tvalid/tready        poll or manual press, time
//  m_axis    out        m_axis_tvalid/tready        state, button, remaining
//  cfg       in         cfg_we_i (no wait)          five setting registers
//
//  Every request is processed in the cycle it is accepted; its result sits
//  in the output register on the next cycle, so one request per cycle unless stalled.
//  The output register is the only buffer: while a result is stalled, a new
//  request is taken in the same cycle the pending result is transferred.
//  Reset loads the default settings and a closed, idle door.
// ----------------------------------------------------------------------------
module door_auto_close_controller
  import dacc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // now_ms [31:0], open_sensor [32], closed_sensor [33], motion_seen [34]
  input  logic [InDataW-1:0]   s_axis_tdata,
  // req_type [0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // door_state [2:0], button_level [3], motion_ack [4],
  // remaining_ms [36:5], attempts_used [40:37]
  output logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic [StateW-1:0] {
    MODE_CLOSED   = 3'd0,
    MODE_OPEN     = 3'd1,
    MODE_MOVING   = 3'd2,
    MODE_ERROR    = 3'd3,
    MODE_DISABLED = 3'd4
  } mode_e;

  // Settings
  logic [TimeW-1:0]  auto_close_q;
  logic [TimeW-1:0]  travel_q;
  logic [CountW-1:0] max_att_q;
  logic [PressW-1:0] press_ms_q;
  logic              btn_level_q;

  // Door state
  mode_e             mode_q, mode_d;
  logic              err_timing_q, err_timing_d;
  logic [TimeW-1:0]  err_since_q, err_since_d;
  logic [TimeW-1:0]  open_since_q, open_since_d;
  logic [CountW-1:0] att_cnt_q, att_cnt_d;
  logic              press_act_q, press_act_d;
  logic [TimeW-1:0]  press_since_q, press_since_d;

  // Result register
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic              s_fire;
  logic [TimeW-1:0]  now;
  logic              op_s, cl_s, motion;
  logic              is_poll;
  logic              err_expired;
  logic              open_expired;
  logic              press_start;
  logic              press_done;
  logic [TimeW-1:0]  err_elapsed;
  logic [TimeW-1:0]  open_elapsed;
  logic [TimeW-1:0]  press_elapsed;
  logic [TimeW-1:0]  rem_elapsed;
  logic [TimeW-1:0]  remaining;
  logic              button;
  logic [CountW-1:0] max_att_clamp;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign now     = s_axis_tdata[TimeW-1:0];
  assign op_s    = s_axis_tdata[TimeW];
  assign cl_s    = s_axis_tdata[TimeW+1];
  assign motion  = s_axis_tdata[TimeW+2];
  assign is_poll = (s_axis_tuser == REQ_POLL);

  assign err_elapsed   = now - err_since_q;
  assign open_elapsed  = now - open_since_q;
  assign press_elapsed = now - press_since_q;
  assign err_expired   = err_timing_q && (err_elapsed >= travel_q);

  always_comb begin
    max_att_clamp = cfg_data_i[CountW-1:0];
    if (max_att_clamp < AttemptMin) begin
      max_att_clamp = AttemptMin;
    end else if (max_att_clamp > AttemptMax) begin
      max_att_clamp = AttemptMax;
    end
  end

  always_comb begin
    mode_d        = mode_q;
    err_timing_d  = err_timing_q;
    err_since_d   = err_since_q;
    open_since_d  = open_since_q;
    att_cnt_d     = att_cnt_q;
    press_start   = 1'b0;
    press_done    = 1'b0;
    open_expired  = 1'b0;

    if (!is_poll) begin
      press_start = 1'b1;
      att_cnt_d   = '0;
    end else begin
      // A freshly started timer has zero elapsed time, which never reaches
      // the clamped limits, so only a running timer can expire here.
      if (op_s && cl_s) begin
        if (!err_timing_q) begin
          err_timing_d = 1'b1;
          err_since_d  = now;
        end
        if (err_expired) begin
          mode_d = MODE_ERROR;
        end
        open_expired = (open_elapsed >= auto_close_q);
      end else begin
        err_timing_d = 1'b0;
        err_since_d  = '0;
        if (op_s) begin
          if (mode_q != MODE_OPEN) begin
            mode_d       = MODE_OPEN;
            open_since_d = now;
            att_cnt_d    = '0;
          end else if (motion) begin
            open_since_d = now;
          end else begin
            open_expired = (open_elapsed >= auto_close_q);
          end
        end else if (cl_s) begin
          mode_d = MODE_CLOSED;
        end else begin
          mode_d = MODE_MOVING;
        end
      end

      if (mode_d == MODE_OPEN && att_cnt_d < max_att_q && open_expired) begin
        press_start = 1'b1;
        att_cnt_d   = att_cnt_d + 1'b1;
      end

      if (att_cnt_d >= max_att_q) begin
        mode_d = MODE_DISABLED;
      end

      // A press started on this poll has zero elapsed time.
      if (press_start) begin
        press_done = (press_ms_q == '0);
      end else begin
        press_done = press_act_q && (press_elapsed >= {16'd0, press_ms_q});
      end
    end

    press_act_d   = (press_start || press_act_q) && !press_done;
    press_since_d = press_start ? now : press_since_q;
  end

  assign rem_elapsed = now - open_since_d;

  always_comb begin
    remaining = '0;
    if (mode_d == MODE_OPEN && rem_elapsed < auto_close_q) begin
      remaining = auto_close_q - rem_elapsed;
    end
    button     = press_act_d ? btn_level_q : !btn_level_q;
    out_data_d = {7'd0, att_cnt_d, remaining, press_start, button, mode_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_close_q  <= AutoCloseReset;
      travel_q      <= TravelReset;
      max_att_q     <= AttemptsReset;
      press_ms_q    <= PressReset;
      btn_level_q   <= 1'b1;
      mode_q        <= MODE_CLOSED;
      err_timing_q  <= 1'b0;
      err_since_q   <= '0;
      open_since_q  <= '0;
      att_cnt_q     <= '0;
      press_act_q   <= 1'b0;
      press_since_q <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_AUTO_CLOSE: begin
            auto_close_q <= (cfg_data_i < AutoCloseMin) ? AutoCloseMin : cfg_data_i;
          end
          CFG_TRAVEL: begin
            travel_q <= (cfg_data_i < TravelMin) ? TravelMin : cfg_data_i;
          end
          CFG_MAX_ATTEMPTS: begin
            max_att_q <= max_att_clamp;
          end
          CFG_PRESS: begin
            press_ms_q <= cfg_data_i[PressW-1:0];
          end
          CFG_BUTTON_LEVEL: begin
            btn_level_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end

      if (s_fire) begin
        mode_q        <= mode_d;
        err_timing_q  <= err_timing_d;
        err_since_q   <= err_since_d;
        open_since_q  <= open_since_d;
        att_cnt_q     <= att_cnt_d;
        press_act_q   <= press_act_d;
        press_since_q <= press_since_d;
        out_valid_q   <= 1'b1;
        out_data_q    <= out_data_d;
      end else if (m_axis_tready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // Remaining open time is reported only for an open door.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != MODE_OPEN) |-> m_axis_tdata[36:5] == '0)
    else $error("remaining time reported for a door that is not open");

  // A press started with a nonzero pulse length stays active afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && press_start && (press_ms_q != '0) |=> press_act_q)
    else $error("button press released on the item that started it");

  // Reaching the attempt limit on a poll always disables the door.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && is_poll && (att_cnt_d >= max_att_q) |=> mode_q == MODE_DISABLED)
    else $error("attempt limit reached without disabling");

  // The attempt counter never passes the largest allowed limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    att_cnt_q <= AttemptMax)
    else $error("attempt counter out of range");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the door auto-close controller. Requests are
// streamed through a driver with random gaps and results are drained by a
// monitor with random stalls. Each accepted request runs through a local
// predictor of the door logic and every result is checked field by field.
// Settings change between phases, including their clamped extremes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dacc_pkg::*;

  typedef enum logic [StateW-1:0] {
    DOOR_CLOSED   = 3'd0,
    DOOR_OPEN     = 3'd1,
    DOOR_MOVING   = 3'd2,
    DOOR_ERROR    = 3'd3,
    DOOR_DISABLED = 3'd4
  } door_state_e;

  typedef struct {
    req_e             req;
    logic [TimeW-1:0] now;
    logic             open_s;
    logic             closed_s;
    logic             motion;
  } door_req_t;

  typedef struct {
    door_state_e       state;
    logic              button;
    logic              ack;
    logic [TimeW-1:0]  remaining;
    logic [CountW-1:0] attempts;
  } door_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  door_auto_close_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Settings as the block should hold them.
  logic [TimeW-1:0]  cfg_auto   = AutoCloseReset;
  logic [TimeW-1:0]  cfg_travel = TravelReset;
  logic [CountW-1:0] cfg_max    = AttemptsReset;
  logic [PressW-1:0] cfg_press  = PressReset;
  logic              cfg_level  = 1'b1;

  // Door state as the block should hold it.
  door_state_e       door_mode   = DOOR_CLOSED;
  logic              err_timing  = 1'b0;
  logic [TimeW-1:0]  err_since   = '0;
  logic [TimeW-1:0]  open_since  = '0;
  logic [CountW-1:0] attempts    = '0;
  logic              press_on    = 1'b0;
  logic [TimeW-1:0]  press_since = '0;

  door_req_t   pending_q[$];
  door_rsp_t   result_q[$];
  door_req_t   on_bus;
  door_rsp_t   want;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int unsigned queued     = 0;
  int unsigned errors     = 0;
  logic [TimeW-1:0] t_now = '0;
  bit          steady     = 1'b0;

  // Elapsed time is taken modulo 2^32, so a timestamp that wrapped still counts.
  function automatic bit expired(logic [TimeW-1:0] t, logic [TimeW-1:0] start,
                                 logic [TimeW-1:0] dur);
    logic [TimeW-1:0] since;
    since = t - start;
    return since >= dur;
  endfunction

  function automatic door_rsp_t door_step(door_req_t it);
    door_rsp_t        r;
    logic [TimeW-1:0] since;
    r.ack       = 1'b0;
    r.remaining = '0;
    if (it.req == REQ_MANUAL) begin
      r.ack       = 1'b1;
      press_on    = 1'b1;
      press_since = it.now;
      attempts    = '0;
    end else begin
      if (it.open_s && it.closed_s) begin
        if (!err_timing) begin
          err_timing = 1'b1;
          err_since  = it.now;
        end
        if (expired(it.now, err_since, cfg_travel)) door_mode = DOOR_ERROR;
      end else begin
        err_timing = 1'b0;
        err_since  = '0;
        if (it.open_s) begin
          if (door_mode != DOOR_OPEN) begin
            door_mode  = DOOR_OPEN;
            open_since = it.now;
            attempts   = '0;
          end else if (it.motion) begin
            open_since = it.now;
          end
        end else if (it.closed_s) begin
          door_mode = DOOR_CLOSED;
        end else begin
          door_mode = DOOR_MOVING;
        end
      end
      if (door_mode == DOOR_OPEN && attempts < cfg_max &&
          expired(it.now, open_since, cfg_auto)) begin
        r.ack       = 1'b1;
        press_on    = 1'b1;
        press_since = it.now;
        attempts    = attempts + 1'b1;
      end
      if (attempts >= cfg_max) door_mode = DOOR_DISABLED;
      if (press_on && expired(it.now, press_since, {16'd0, cfg_press})) press_on = 1'b0;
    end
    if (door_mode == DOOR_OPEN) begin
      since = it.now - open_since;
      if (since < cfg_auto) r.remaining = cfg_auto - since;
    end
    r.state    = door_mode;
    r.button   = press_on ? cfg_level : ~cfg_level;
    r.attempts = attempts;
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string name, logic [TimeW-1:0] exp_v, logic [TimeW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) result_q.push_back(door_step(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          on_bus = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'd0, on_bus.motion, on_bus.closed_s, on_bus.open_s, on_bus.now};
          s_axis_tuser  <= on_bus.req;
          send_gap = steady ? 0 : gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("door_state", TimeW'(want.state), TimeW'(m_axis_tdata[2:0]));
          check_field("button_level", TimeW'(want.button), TimeW'(m_axis_tdata[3]));
          check_field("motion_ack", TimeW'(want.ack), TimeW'(m_axis_tdata[4]));
          check_field("remaining_ms", want.remaining, m_axis_tdata[36:5]);
          check_field("attempts_used", TimeW'(want.attempts), TimeW'(m_axis_tdata[40:37]));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0) stall_left = gap_len();
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_AUTO_CLOSE: cfg_auto = (data < AutoCloseMin) ? AutoCloseMin : data;
      CFG_TRAVEL:     cfg_travel = (data < TravelMin) ? TravelMin : data;
      CFG_MAX_ATTEMPTS: begin
        cfg_max = data[CountW-1:0];
        if (cfg_max < AttemptMin) cfg_max = AttemptMin;
        else if (cfg_max > AttemptMax) cfg_max = AttemptMax;
      end
      CFG_PRESS:        cfg_press = data[PressW-1:0];
      CFG_BUTTON_LEVEL: cfg_level = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic random_config();
    logic [CfgDataW-1:0] v;
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59999) : $urandom_range(60000, 400000);
    write_reg(CFG_AUTO_CLOSE, v);
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) : $urandom_range(1000, 80000);
    write_reg(CFG_TRAVEL, v);
    v = $urandom_range(0, 15);
    if ($urandom_range(0, 2) == 0) v = v | ($urandom() & 32'hFFFF_FFF0);
    write_reg(CFG_MAX_ATTEMPTS, v);
    v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000);
    write_reg(CFG_PRESS, v);
    write_reg(CFG_BUTTON_LEVEL, $urandom());
    // Indexes past the last register must leave every setting alone.
    if ($urandom_range(0, 1) == 0) write_reg(CfgIdxW'($urandom_range(5, 7)), $urandom());
  endtask

  task automatic queue_item(req_e req, logic [TimeW-1:0] t, logic op, logic cl, logic mot);
    door_req_t it;
    t_now       = t;
    it.req      = req;
    it.now      = t;
    it.open_s   = op;
    it.closed_s = cl;
    it.motion   = mot;
    pending_q.push_back(it);
    queued++;
  endtask

  task automatic poll_after(logic [TimeW-1:0] dt, logic op, logic cl, logic mot);
    queue_item(REQ_POLL, t_now + dt, op, cl, mot);
  endtask

  // Door-like sequences with random timing, plus some pure noise.
  task automatic random_items(int unsigned n);
    int unsigned start, k, reps, i;
    start = queued;
    while (queued - start < n) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      k = $urandom_range(0, 99);
      if (k < 35) begin
        reps = $urandom_range(4, 24);
        for (i = 0; i < reps; i++)
          poll_after($urandom_range(0, cfg_auto / 5), 1'b1, 1'b0, $urandom_range(0, 99) < 15);
      end else if (k < 55) begin
        reps = $urandom_range(1, 4);
        for (i = 0; i < reps; i++)
          poll_after($urandom_range(0, 2000), 1'b0, 1'b0, 1'($urandom()));
        reps = $urandom_range(1, 5);
        for (i = 0; i < reps; i++)
          poll_after($urandom_range(0, 5000), 1'b0, 1'b1, 1'($urandom()));
      end else if (k < 65) begin
        reps = $urandom_range(2, 8);
        for (i = 0; i < reps; i++)
          poll_after($urandom_range(0, cfg_travel / 3), 1'b1, 1'b1, 1'($urandom()));
      end else if (k < 75) begin
        queue_item(REQ_MANUAL, t_now + $urandom_range(0, 1000), 1'($urandom()),
                   1'($urandom()), 1'($urandom()));
      end else if (k < 85) begin
        reps = $urandom_range(2, 6);
        for (i = 0; i < reps; i++)
          poll_after($urandom_range(0, cfg_press), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
      end else begin
        queue_item(req_e'($urandom_range(0, 1)), $urandom(), 1'($urandom()), 1'($urandom()),
                   1'($urandom()));
      end
    end
  endtask

  // Wait for the request queue to empty and every result to arrive.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned p;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default settings: press and release, motion restart, repeated expiry up to
    // the limit, leaving disabled, the error delay and a wrapped timestamp.
    queue_item(REQ_POLL, 0, 1'b0, 1'b1, 1'b0);
    queue_item(REQ_MANUAL, 10, 1'b1, 1'b1, 1'b1);
    queue_item(REQ_POLL, 600, 1'b0, 1'b1, 1'b0);
    queue_item(REQ_POLL, 1000, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 2000, 1'b1, 1'b0, 1'b1);
    queue_item(REQ_POLL, 302000, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 302100, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 302200, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 302300, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 302400, 1'b1, 1'b1, 1'b0);
    queue_item(REQ_POLL, 332399, 1'b1, 1'b1, 1'b1);
    queue_item(REQ_POLL, 332400, 1'b1, 1'b1, 1'b0);
    queue_item(REQ_POLL, 332500, 1'b0, 1'b0, 1'b0);
    queue_item(REQ_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
    queue_item(REQ_POLL, 299990, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 300000, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_MANUAL, 300001, 1'b0, 1'b0, 1'b0);
    random_items(200);
    drain();

    // Every setting written below its floor.
    write_reg(CFG_AUTO_CLOSE, 0);
    write_reg(CFG_TRAVEL, 0);
    write_reg(CFG_MAX_ATTEMPTS, 0);
    write_reg(CFG_PRESS, 0);
    write_reg(CFG_BUTTON_LEVEL, 0);
    // A single attempt disables at once and a zero-length press ends on its own poll.
    queue_item(REQ_POLL, 500, 1'b0, 1'b1, 1'b0);
    queue_item(REQ_POLL, 1000, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 61000, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 61001, 1'b1, 1'b1, 1'b0);
    random_items(240);
    drain();

    // Every setting at its ceiling, the attempt limit written above its range.
    write_reg(CFG_AUTO_CLOSE, 32'hFFFF_FFFF);
    write_reg(CFG_TRAVEL, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_ATTEMPTS, 15);
    write_reg(CFG_PRESS, 32'h0000_FFFF);
    write_reg(CFG_BUTTON_LEVEL, 1);
    // One millisecond short of a full wrap is the only time that reaches the maximum.
    queue_item(REQ_POLL, 50, 1'b0, 1'b1, 1'b0);
    queue_item(REQ_POLL, 100, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 99, 1'b1, 1'b0, 1'b0);
    queue_item(REQ_POLL, 200, 1'b1, 1'b1, 1'b0);
    queue_item(REQ_POLL, 199, 1'b1, 1'b1, 1'b0);
    random_items(200);
    drain();

    for (p = 0; p < 6; p++) begin
      random_config();
      steady = ($urandom_range(0, 3) == 0);
      random_items(220);
      drain();
    end

    if (errors == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
hdl/dacc_pkg.sv
hdl/door_auto_close_controller.sv
dv/tb_top.sv
